FILE: rtl/mqtt_packet_deframer_core_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef MQTT_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mpd_pkg.sv
// Types and constants shared by the packet deframer modules.
`timescale 1ns / 1ps

package mpd_pkg;

  // Remaining-length field limits.
  localparam int unsigned MAX_LEN_BYTES = 4;
  localparam int unsigned LEN_CNT_W     = 2;
  localparam int unsigned LEN_W         = 28;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Control packet types that get special handling.
  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  // Front parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  // Class of a byte as decided by the front.
  typedef enum logic [2:0] {
    CLS_HEADER   = 3'd0,
    CLS_LEN_MORE = 3'd1,
    CLS_LEN_ERR  = 3'd2,
    CLS_LEN_END  = 3'd3,
    CLS_BODY     = 3'd4
  } cls_e;

  // Event reported with each result.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_TOPIC   = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_CONN_OK = 3'd3,
    EV_DONE    = 3'd4,
    EV_LEN_ERR = 3'd5
  } event_e;

  // One classified byte travelling through the queue.
  typedef struct packed {
    cls_e             cls;
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] plen;
  } item_t;

endpackage

FILE: rtl/mpd_front.sv
// Front end: accepts stream bytes and tracks header, length and body framing.
`timescale 1ns / 1ps

module mpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_data_i,
  input  logic           q_ready_i,
  output logic           q_push_o,
  output mpd_pkg::item_t q_item_o
);

  mpd_pkg::phase_e                     phase_q, phase_d;
  logic [mpd_pkg::LEN_W-1:0]           accum_q, accum_d;
  logic [mpd_pkg::LEN_CNT_W-1:0]       cnt_q, cnt_d;
  logic [mpd_pkg::LEN_W-1:0]           left_q, left_d;
  logic [mpd_pkg::LEN_W-1:0]           group;
  logic                                accept;
  logic                                final_byte;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign q_push_o   = accept;

  // Place the 7 value bits of a length byte by its position.
  always_comb begin
    case (cnt_q)
      2'd0:    group = {21'b0, in_data_i[6:0]};
      2'd1:    group = {14'b0, in_data_i[6:0], 7'b0};
      2'd2:    group = {7'b0, in_data_i[6:0], 14'b0};
      default: group = {in_data_i[6:0], 21'b0};
    endcase
  end

  assign final_byte = (left_q <= mpd_pkg::LEN_W'(1));

  // Classify the byte and work out the next framing state.
  always_comb begin
    phase_d       = phase_q;
    accum_d       = accum_q;
    cnt_d         = cnt_q;
    left_d        = left_q;
    q_item_o.cls  = mpd_pkg::CLS_HEADER;
    q_item_o.data = in_data_i;
    q_item_o.last = 1'b0;
    q_item_o.plen = '0;
    case (phase_q)
      mpd_pkg::PH_LENGTH: begin
        accum_d = accum_q | group;
        if (in_data_i[7]) begin
          if (({1'b0, cnt_q} + 3'd1) >= 3'(mpd_pkg::MAX_LEN_BYTES)) begin
            q_item_o.cls = mpd_pkg::CLS_LEN_ERR;
            phase_d      = mpd_pkg::PH_HEADER;
          end else begin
            q_item_o.cls = mpd_pkg::CLS_LEN_MORE;
            cnt_d        = cnt_q + 2'd1;
          end
        end else begin
          q_item_o.cls  = mpd_pkg::CLS_LEN_END;
          q_item_o.plen = accum_d;
          left_d        = accum_d;
          phase_d       = (accum_d == '0) ? mpd_pkg::PH_HEADER : mpd_pkg::PH_BODY;
        end
      end
      mpd_pkg::PH_BODY: begin
        q_item_o.cls  = mpd_pkg::CLS_BODY;
        q_item_o.last = final_byte;
        if (final_byte) begin
          left_d  = '0;
          phase_d = mpd_pkg::PH_HEADER;
        end else begin
          left_d = left_q - mpd_pkg::LEN_W'(1);
        end
      end
      default: begin
        accum_d = '0;
        cnt_d   = '0;
        left_d  = '0;
        phase_d = mpd_pkg::PH_LENGTH;
      end
    endcase
  end

  // Framing state advances on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpd_pkg::PH_HEADER;
      accum_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: rtl/mpd_queue.sv
// Short queue of classified bytes between the front and the back.
`timescale 1ns / 1ps

module mpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpd_pkg::item_t push_item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mpd_pkg::item_t pop_item_o
);

  `include "mqtt_packet_deframer_core_assert.svh"

  mpd_pkg::item_t                mem_q [mpd_pkg::QDEPTH];
  logic [mpd_pkg::QAW-1:0]       wr_q, wr_d;
  logic [mpd_pkg::QAW-1:0]       rd_q, rd_d;
  logic [mpd_pkg::QCW-1:0]       cnt_q, cnt_d;
  logic                          full;

  assign full       = (cnt_q == mpd_pkg::QCW'(mpd_pkg::QDEPTH));
  assign ready_o    = ~full;
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_q];

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == mpd_pkg::QAW'(mpd_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == mpd_pkg::QAW'(mpd_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  `MPD_ASSERT_NOW(a_no_push_full, full, !push_i, "push into full queue")
  `MPD_ASSERT_NOW(a_no_pop_empty, pop_i, cnt_q != '0, "pop from empty queue")

endmodule

FILE: rtl/mpd_back.sv
// Back end: interprets packet bodies and holds the result register.
`timescale 1ns / 1ps

module mpd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  mpd_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     event_kind_o,
  output logic [7:0]     byte_value_o,
  output logic           message_last_o,
  output logic [3:0]     packet_kind_o,
  output logic [15:0]    topic_size_o
);

  `include "mqtt_packet_deframer_core_assert.svh"

  logic [3:0]                  type_q, type_d;
  logic [mpd_pkg::LEN_W-1:0]   plen_q, plen_d;
  logic [1:0]                  pos_q, pos_d;
  logic [15:0]                 tlen_q, tlen_d;
  logic [15:0]                 tleft_q, tleft_d;
  logic                        cgood_q, cgood_d;
  logic                        discard_q, discard_d;
  logic                        take;
  logic                        delivered;
  mpd_pkg::event_e             ev;
  logic [7:0]                  val;
  logic                        last;

  logic                        valid_q;
  mpd_pkg::event_e             ev_q;
  logic [7:0]                  val_q;
  logic                        last_q;
  logic [3:0]                  pkind_q;
  logic [15:0]                 tsize_q;

  logic                        msg_ev;
  logic                        pkind_pub;

  // A queued byte is taken whenever the result register is free or drains.
  assign take    = q_valid_i & (~valid_q | out_ready_i);
  assign q_pop_o = take;

  // Body interpretation for the byte at the head of the queue.
  always_comb begin
    type_d    = type_q;
    plen_d    = plen_q;
    pos_d     = pos_q;
    tlen_d    = tlen_q;
    tleft_d   = tleft_q;
    cgood_d   = cgood_q;
    discard_d = discard_q;
    delivered = 1'b0;
    ev        = mpd_pkg::EV_NONE;
    val       = 8'd0;
    last      = 1'b0;
    case (q_item_i.cls)
      mpd_pkg::CLS_HEADER: begin
        type_d    = q_item_i.data[7:4];
        plen_d    = '0;
        pos_d     = 2'd0;
        tlen_d    = 16'd0;
        tleft_d   = 16'd0;
        cgood_d   = 1'b0;
        discard_d = (q_item_i.data[7:4] != mpd_pkg::TYPE_PUBLISH);
      end
      mpd_pkg::CLS_LEN_MORE: begin
        ev = mpd_pkg::EV_NONE;
      end
      mpd_pkg::CLS_LEN_ERR: begin
        ev = mpd_pkg::EV_LEN_ERR;
      end
      mpd_pkg::CLS_LEN_END: begin
        plen_d = q_item_i.plen;
        if (q_item_i.plen == '0) begin
          ev = mpd_pkg::EV_DONE;
        end
      end
      mpd_pkg::CLS_BODY: begin
        if (type_q == mpd_pkg::TYPE_PUBLISH && !discard_q) begin
          if (pos_q == 2'd0) begin
            tlen_d = {q_item_i.data, 8'd0};
            pos_d  = 2'd1;
          end else if (pos_q == 2'd1) begin
            tlen_d = {tlen_q[15:8], q_item_i.data};
            pos_d  = 2'd2;
            // Topic must fit in the body after its two length bytes.
            if (plen_q < mpd_pkg::LEN_W'(4) ||
                mpd_pkg::LEN_W'(tlen_d) > (plen_q - mpd_pkg::LEN_W'(2))) begin
              discard_d = 1'b1;
            end else begin
              tleft_d = tlen_d;
            end
          end else begin
            delivered = 1'b1;
            val       = q_item_i.data;
            last      = q_item_i.last;
            if (tleft_q != 16'd0) begin
              ev      = mpd_pkg::EV_TOPIC;
              tleft_d = tleft_q - 16'd1;
            end else begin
              ev = mpd_pkg::EV_PAYLOAD;
            end
          end
        end else begin
          if (type_q == mpd_pkg::TYPE_CONNACK && pos_q == 2'd1 &&
              q_item_i.data == 8'd0) begin
            cgood_d = 1'b1;
          end
          if (pos_q != 2'd2) begin
            pos_d = pos_q + 2'd1;
          end
        end
        if (q_item_i.last && !delivered) begin
          ev = (type_q == mpd_pkg::TYPE_CONNACK && cgood_d) ?
               mpd_pkg::EV_CONN_OK : mpd_pkg::EV_DONE;
        end
      end
      default: begin
        ev = mpd_pkg::EV_NONE;
      end
    endcase
  end

  // Packet context registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= 4'd0;
      plen_q    <= '0;
      pos_q     <= 2'd0;
      tlen_q    <= 16'd0;
      tleft_q   <= 16'd0;
      cgood_q   <= 1'b0;
      discard_q <= 1'b0;
    end else if (take) begin
      type_q    <= type_d;
      plen_q    <= plen_d;
      pos_q     <= pos_d;
      tlen_q    <= tlen_d;
      tleft_q   <= tleft_d;
      cgood_q   <= cgood_d;
      discard_q <= discard_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q    <= ev;
      val_q   <= val;
      last_q  <= last;
      pkind_q <= type_d;
      tsize_q <= (type_d == mpd_pkg::TYPE_PUBLISH && pos_d == 2'd2) ? tlen_d : 16'd0;
    end
  end

  assign out_valid_o    = valid_q;
  assign event_kind_o   = ev_q;
  assign byte_value_o   = val_q;
  assign message_last_o = last_q;
  assign packet_kind_o  = pkind_q;
  assign topic_size_o   = tsize_q;

  // Properties of the held result.
  assign msg_ev    = (ev_q == mpd_pkg::EV_TOPIC) || (ev_q == mpd_pkg::EV_PAYLOAD);
  assign pkind_pub = (pkind_q == mpd_pkg::TYPE_PUBLISH);

  `MPD_ASSERT_NOW(a_msg_is_publish, valid_q && msg_ev, pkind_pub, "message byte outside publish")
  `MPD_ASSERT_NOW(a_last_on_msg, valid_q && last_q, msg_ev, "last flag without message byte")
  `MPD_ASSERT_NEXT(a_hold_stalled, valid_q && !out_ready_i, valid_q, "result dropped in stall")

endmodule

FILE: rtl/mqtt_packet_deframer_core.sv
// Top level of the MQTT receive deframer.
`timescale 1ns / 1ps

// Takes one stream byte per cycle while the queue has room and gives exactly one
// result transfer per byte. The front tracks the header, remaining-length and
// body framing; a two-entry queue carries each classified byte to the back,
// which decodes CONNACK and PUBLISH bodies into the result register. Sustained
// rate is one byte per cycle while the queue has room, set by the framing update
// in the front; a result reaches the master side through the queue and then the
// result register, and input keeps flowing while a result waits, until the queue
// fills. Result tuser bits [2:0] carry the event (0 none, 1 topic byte, 2 payload
// byte, 3 connection accepted, 4 packet done undelivered, 5 length error) and
// tlast marks the final byte of a delivered PUBLISH.
module mqtt_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] byte_value, [23:8] topic_size
  output logic [6:0]  m_axis_tuser,  // [2:0] event_kind, [6:3] packet_kind
  output logic        m_axis_tlast   // message_last
);

  mpd_pkg::item_t push_item;
  mpd_pkg::item_t pop_item;
  logic           push;
  logic           q_ready;
  logic           q_valid;
  logic           pop;
  logic [2:0]     event_kind;
  logic [7:0]     byte_value;
  logic [3:0]     packet_kind;
  logic [15:0]    topic_size;

  mpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_ready_i  (q_ready),
    .q_push_o   (push),
    .q_item_o   (push_item)
  );

  mpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  mpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .q_pop_o        (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .event_kind_o   (event_kind),
    .byte_value_o   (byte_value),
    .message_last_o (m_axis_tlast),
    .packet_kind_o  (packet_kind),
    .topic_size_o   (topic_size)
  );

  // Pack result fields onto the master side.
  assign m_axis_tdata = {topic_size, byte_value};
  assign m_axis_tuser = {packet_kind, event_kind};

endmodule

FILE: verif/tb_mqtt_packet_deframer_core.sv
// Self-checking stream testbench for the MQTT receive deframer core.
`timescale 1ns / 1ps

module tb_mqtt_packet_deframer_core;
  import mpd_pkg::*;

  // One expected or observed result transfer, field by field.
  typedef struct packed {
    event_e      ev;
    logic [7:0]  val;
    logic        last;
    logic [3:0]  pkind;
    logic [15:0] tsize;
  } frame_res_t;

  // One row of the directed table; typed rows carry their own expected event.
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    event_e     ev;
    logic [3:0] pkind;
  } dir_row_t;

  // One planned stream byte.
  typedef struct {
    logic [7:0] b;
    logic       typed;
    frame_res_t exp;
    logic       drain;
  } plan_entry_t;

  localparam int DIR_ROWS     = 27;
  localparam int RANDOM_BYTES = 450;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // CONNACK header right after reset, with its flag nibble set.
    '{8'h2F, 1'b1, EV_NONE, TYPE_CONNACK},
    // Zero remaining length ends the packet at once, even for a CONNACK.
    '{8'h00, 1'b1, EV_DONE, TYPE_CONNACK},
    // Well-formed CONNACK with a zero return code.
    '{8'h20, 1'b0, EV_NONE, 4'h0},
    '{8'h02, 1'b0, EV_NONE, 4'h0},
    '{8'h00, 1'b0, EV_NONE, 4'h0},
    '{8'h00, 1'b1, EV_CONN_OK, TYPE_CONNACK},
    // CONNACK with only one body byte has no return code.
    '{8'h20, 1'b0, EV_NONE, 4'h0},
    '{8'h01, 1'b0, EV_NONE, 4'h0},
    '{8'h00, 1'b1, EV_DONE, TYPE_CONNACK},
    // Four length bytes all with the continuation bit set.
    '{8'h30, 1'b0, EV_NONE, 4'h0},
    '{8'h80, 1'b0, EV_NONE, 4'h0},
    '{8'h80, 1'b0, EV_NONE, 4'h0},
    '{8'h80, 1'b0, EV_NONE, 4'h0},
    '{8'hFF, 1'b1, EV_LEN_ERR, TYPE_PUBLISH},
    // Delivered PUBLISH: one topic byte, two payload bytes, flags ignored.
    '{8'h3F, 1'b0, EV_NONE, 4'h0},
    '{8'h05, 1'b0, EV_NONE, 4'h0},
    '{8'h00, 1'b0, EV_NONE, 4'h0},
    '{8'h01, 1'b0, EV_NONE, 4'h0},
    '{8'hFF, 1'b0, EV_NONE, 4'h0},
    '{8'h00, 1'b0, EV_NONE, 4'h0},
    '{8'h80, 1'b0, EV_NONE, 4'h0},
    // PUBLISH whose topic length does not fit in its body.
    '{8'h30, 1'b0, EV_NONE, 4'h0},
    '{8'h04, 1'b0, EV_NONE, 4'h0},
    '{8'hFF, 1'b0, EV_NONE, 4'h0},
    '{8'hFF, 1'b0, EV_NONE, 4'h0},
    '{8'h01, 1'b0, EV_NONE, 4'h0},
    '{8'h02, 1'b0, EV_NONE, 4'h0}
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic [6:0]  m_axis_tuser;
  logic        m_axis_tlast;

  mqtt_packet_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Planned stream and results still owed by the block.
  plan_entry_t stream_plan[$];
  frame_res_t  pending_results[$];
  int          sent_cnt     = 0;
  int          checked_cnt  = 0;
  int          mismatch_cnt = 0;
  int          ev_seen [8];

  // Deframer state as the predictor tracks it.
  phase_e           rx_phase;
  logic [3:0]       cur_type;
  logic [LEN_W-1:0] len_acc;
  logic [1:0]       len_seen;
  logic [LEN_W-1:0] body_left;
  logic [1:0]       body_pos;
  logic [15:0]      topic_len;
  logic [15:0]      topic_left;
  logic             conn_ok;
  logic             discard;

  task automatic deframer_clear();
    rx_phase   = PH_HEADER;
    cur_type   = '0;
    len_acc    = '0;
    len_seen   = '0;
    body_left  = '0;
    body_pos   = '0;
    topic_len  = '0;
    topic_left = '0;
    conn_ok    = 1'b0;
    discard    = 1'b0;
  endtask

  // Advances the deframer state by one stream byte and gives its result.
  task automatic deframe_byte(input logic [7:0] b, output frame_res_t r);
    int unsigned shift;
    logic        is_end;
    logic        delivered;
    r         = '0;
    r.ev      = EV_NONE;
    delivered = 1'b0;
    case (rx_phase)
      PH_LENGTH: begin
        shift   = 7 * len_seen;
        len_acc = len_acc | ({21'd0, b[6:0]} << shift);
        if (b[7]) begin
          if (len_seen + 1 >= MAX_LEN_BYTES) begin
            r.ev     = EV_LEN_ERR;
            rx_phase = PH_HEADER;
          end else begin
            len_seen = len_seen + 2'd1;
          end
        end else begin
          body_left = len_acc;
          if (body_left == '0) begin
            r.ev     = EV_DONE;
            rx_phase = PH_HEADER;
          end else begin
            rx_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        is_end    = (body_left <= 1);
        body_left = is_end ? '0 : body_left - 1'b1;
        if (cur_type == TYPE_PUBLISH && !discard) begin
          if (body_pos == 2'd0) begin
            topic_len = {b, 8'h00};
            body_pos  = 2'd1;
          end else if (body_pos == 2'd1) begin
            topic_len = topic_len | {8'h00, b};
            body_pos  = 2'd2;
            // The topic must fit after its own two length bytes.
            if (len_acc < 4 || {12'd0, topic_len} > len_acc - 2) begin
              discard = 1'b1;
            end else begin
              topic_left = topic_len;
            end
          end else begin
            delivered = 1'b1;
            r.val     = b;
            if (topic_left > 0) begin
              r.ev       = EV_TOPIC;
              topic_left = topic_left - 1'b1;
            end else begin
              r.ev = EV_PAYLOAD;
            end
            r.last = is_end;
          end
        end else begin
          if (cur_type == TYPE_CONNACK && body_pos == 2'd1 && b == 8'h00) conn_ok = 1'b1;
          if (body_pos < 2'd2) body_pos = body_pos + 2'd1;
        end
        if (is_end) begin
          rx_phase = PH_HEADER;
          if (!delivered) r.ev = (cur_type == TYPE_CONNACK && conn_ok) ? EV_CONN_OK : EV_DONE;
        end
      end
      default: begin
        cur_type   = b[7:4];
        len_acc    = '0;
        len_seen   = '0;
        body_left  = '0;
        body_pos   = '0;
        topic_len  = '0;
        topic_left = '0;
        conn_ok    = 1'b0;
        discard    = (cur_type != TYPE_PUBLISH);
        rx_phase   = PH_LENGTH;
      end
    endcase
    r.pkind = cur_type;
    r.tsize = (cur_type == TYPE_PUBLISH && body_pos == 2'd2) ? topic_len : 16'h0000;
  endtask

  task automatic plan_byte(input logic [7:0] b);
    plan_entry_t e;
    e.b     = b;
    e.typed = 1'b0;
    e.exp   = '0;
    e.drain = 1'b0;
    stream_plan.push_back(e);
  endtask

  // Remaining length, least significant group first, sometimes padded with
  // redundant continuation groups.
  task automatic plan_length(input int unsigned v);
    int unsigned groups;
    int          i;
    logic        cont;
    groups = 1;
    while ((v >> (7 * groups)) != 0 && groups < MAX_LEN_BYTES) groups++;
    if ($urandom_range(0, 5) == 0) groups = $urandom_range(groups, MAX_LEN_BYTES);
    for (i = 0; i < groups; i++) begin
      cont = (i + 1 < groups);
      plan_byte({cont, 7'(v >> (7 * i))});
    end
  endtask

  // One packet of random content; mostly well formed, some broken or noise.
  task automatic plan_packet();
    int unsigned sel, tlen, plen, rlen, tfield;
    int          i;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      plan_byte({TYPE_PUBLISH, 4'($urandom)});
      tlen   = $urandom_range(0, 8);
      plen   = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 250) : $urandom_range(0, 10);
      rlen   = 2 + tlen + plen;
      tfield = tlen;
      case ($urandom_range(0, 9))
        0: rlen = $urandom_range(0, 3);
        1: tfield = $urandom_range(rlen - 1, 65535);
        default: ;
      endcase
      plan_length(rlen);
      for (i = 0; i < rlen; i++) begin
        if (i == 0) plan_byte(8'(tfield >> 8));
        else if (i == 1) plan_byte(8'(tfield));
        else plan_byte(8'($urandom));
      end
    end else if (sel < 65) begin
      plan_byte({TYPE_CONNACK, 4'($urandom)});
      rlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2;
      plan_length(rlen);
      for (i = 0; i < rlen; i++) begin
        if (i == 1 && $urandom_range(0, 1) == 1) plan_byte(8'h00);
        else plan_byte(8'($urandom));
      end
    end else if (sel < 82) begin
      plan_byte(8'($urandom));
      rlen = $urandom_range(0, 12);
      plan_length(rlen);
      for (i = 0; i < rlen; i++) plan_byte(8'($urandom));
    end else if (sel < 92) begin
      // Length field that never ends.
      plan_byte(8'($urandom));
      for (i = 0; i < MAX_LEN_BYTES; i++) plan_byte({1'b1, 7'($urandom)});
    end else begin
      plan_byte(8'($urandom));
      plan_length(0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR [%0t] result %0d: %s", $realtime, checked_cnt, msg);
    mismatch_cnt++;
  endtask

  task automatic check_result(input frame_res_t want, input frame_res_t got);
    if (got.ev !== want.ev)
      report_mismatch($sformatf("event_kind expected %0d, got %0d", want.ev, got.ev));
    if (got.val !== want.val)
      report_mismatch($sformatf("byte_value expected 0x%0h, got 0x%0h", want.val, got.val));
    if (got.last !== want.last)
      report_mismatch($sformatf("message_last expected %0d, got %0d", want.last, got.last));
    if (got.pkind !== want.pkind)
      report_mismatch($sformatf("packet_kind expected %0d, got %0d", want.pkind, got.pkind));
    if (got.tsize !== want.tsize)
      report_mismatch($sformatf("topic_size expected 0x%0h, got 0x%0h", want.tsize, got.tsize));
  endtask

  // Build the stream plan, then hold reset.
  initial begin : reset_and_plan
    plan_entry_t e;
    int          i;
    deframer_clear();
    for (i = 0; i < 8; i++) ev_seen[i] = 0;
    for (i = 0; i < DIR_ROWS; i++) begin
      e.b       = DIRECTED[i].b;
      e.typed   = DIRECTED[i].typed;
      e.exp     = '0;
      e.exp.ev  = DIRECTED[i].ev;
      e.exp.pkind = DIRECTED[i].pkind;
      e.drain   = 1'b0;
      stream_plan.push_back(e);
    end
    while (stream_plan.size() < DIR_ROWS + RANDOM_BYTES) plan_packet();
    // The sender holds off after the directed part until the block drains.
    stream_plan[DIR_ROWS].drain = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Handshake state sampled mid-cycle, where nothing is changing.
  logic       s_fire = 1'b0;
  logic       m_fire = 1'b0;
  frame_res_t got_res;

  always @(negedge clk_i) begin
    s_fire        = s_valid && s_axis_tready;
    m_fire        = m_axis_tvalid && m_ready;
    got_res.ev    = event_e'(m_axis_tuser[2:0]);
    got_res.val   = m_axis_tdata[7:0];
    got_res.last  = m_axis_tlast;
    got_res.pkind = m_axis_tuser[6:3];
    got_res.tsize = m_axis_tdata[23:8];
  end

  // Sender bursts and gaps, receiver stall modes, prediction and checking.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_left    = 0;
  int unsigned cyc_cnt    = 0;

  always @(posedge clk_i) begin : stream_ctrl
    frame_res_t want;
    logic       nv;
    logic       nr;
    if (rst_ni) begin
      cyc_cnt++;

      // A byte transfer at this edge: predict its result.
      if (s_fire) begin
        deframe_byte(stream_plan[sent_cnt].b, want);
        if (stream_plan[sent_cnt].typed) want = stream_plan[sent_cnt].exp;
        pending_results.push_back(want);
        sent_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end

      // Valid stays up until its byte is taken.
      nv = s_valid;
      if (!s_valid || s_fire) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sent_cnt < stream_plan.size()) begin
          if (!stream_plan[sent_cnt].drain || pending_results.size() == 0) nv = 1'b1;
        end
      end
      s_valid <= nv;
      if (nv) s_data <= stream_plan[sent_cnt].b;

      // A result transfer at this edge: compare with the oldest prediction.
      if (m_fire) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no prediction waiting");
        end else begin
          want = pending_results.pop_front();
          check_result(want, got_res);
        end
        ev_seen[got_res.ev]++;
        checked_cnt++;
      end

      // Receiver stall pattern: switches at random among four modes.
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(32, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: nr = 1'b1;
        1: nr = ($urandom_range(0, 1) == 1);
        2: nr = (cyc_cnt % 3 != 0);
        default: nr = ($urandom_range(0, 7) == 0);
      endcase
      m_ready <= nr;
    end
  end

  // Normal end of the run.
  initial begin : finish_run
    wait (rst_ni);
    while (sent_cnt < stream_plan.size() || pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("Run covered %0d stream bytes (%0d directed) and %0d result transfers.",
             sent_cnt, DIR_ROWS, checked_cnt);
    $display("Events: %0d topic, %0d payload, %0d accepted, %0d skipped, %0d length errors.",
             ev_seen[EV_TOPIC], ev_seen[EV_PAYLOAD], ev_seen[EV_CONN_OK], ev_seen[EV_DONE],
             ev_seen[EV_LEN_ERR]);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d of %0d bytes sent and %0d results outstanding.",
             sent_cnt, stream_plan.size(), pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
